/* rtl/core/msseq_pkg.sv */
// Package for the mutating step sequencer: sizes, request layouts, register
// indexes, controller command and status structures and the pitch tables.
// Has no dependencies; every other file of the block imports it.
`default_nettype none

package msseq_pkg;

    localparam int STEP_COUNT = 8;
    localparam int IDX_W      = $clog2(STEP_COUNT);
    localparam int ALEN_W     = $clog2(STEP_COUNT + 1);
    localparam int REM_W      = ALEN_W + 1;

    localparam int OCT_W   = 3;
    localparam int SEMI_W  = 4;
    localparam int LEN_W   = 4;
    localparam int PER_W   = 8;
    localparam int ODEP_W  = 3;
    localparam int SDEP_W  = 4;
    localparam int RAND_W  = 16;
    localparam int PITCH_W = 10;
    localparam int LOCK_W  = 8;
    localparam int OSTEP_W = 3;

    localparam logic [OCT_W-1:0]  OCT_MAX  = 3'd6;
    localparam logic [SEMI_W-1:0] SEMI_MAX = 4'd11;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

    // Remainder unit: four bits of the random word per cycle.
    localparam int MOD_BITS   = 4;
    localparam int MOD_CYCLES = RAND_W / MOD_BITS;
    localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LENGTH,
        CFG_PERIOD,
        CFG_OCT_DEPTH,
        CFG_SEMI_DEPTH
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]        pad;
        logic [SEMI_W-1:0] random_semitone;
        logic [OCT_W-1:0]  random_octave;
        logic [3:0]        mutation_flags;
        logic [RAND_W-1:0] random_step;
        logic [SEMI_W-1:0] knob_semitone_value;
        logic [OCT_W-1:0]  knob_octave_value;
        logic [2:0]        knob_step;
        logic [LOCK_W-1:0] lock_buttons;
        logic              clock_level;
    } in_item_t;

    typedef struct packed {
        logic [2:0]                pad;
        logic [LOCK_W-1:0]         lock_mask;
        logic signed [PITCH_W-1:0] pitch_centivolts;
        logic [OSTEP_W-1:0]        current_step;
    } out_item_t;

    typedef struct packed {
        logic latch;
        logic knob_wr;
        logic tick;
        logic mod_step;
        logic mutate;
        logic finish;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic mutate_due;
    } status_t;

    function automatic logic signed [PITCH_W-1:0] octave_cv(input logic [OCT_W-1:0] oct);
        logic signed [PITCH_W-1:0] cv;
        unique case (oct)
            3'd0:    cv = -10'sd200;
            3'd1:    cv = -10'sd100;
            3'd2:    cv = 10'sd0;
            3'd3:    cv = 10'sd100;
            3'd4:    cv = 10'sd200;
            3'd5:    cv = 10'sd300;
            default: cv = 10'sd400;
        endcase
        return cv;
    endfunction

    function automatic logic signed [PITCH_W-1:0] semitone_cv(input logic [SEMI_W-1:0] semi);
        logic signed [PITCH_W-1:0] cv;
        unique case (semi)
            4'd0:    cv = 10'sd0;
            4'd1:    cv = 10'sd8;
            4'd2:    cv = 10'sd17;
            4'd3:    cv = 10'sd25;
            4'd4:    cv = 10'sd33;
            4'd5:    cv = 10'sd42;
            4'd6:    cv = 10'sd50;
            4'd7:    cv = 10'sd58;
            4'd8:    cv = 10'sd67;
            4'd9:    cv = 10'sd75;
            4'd10:   cv = 10'sd83;
            default: cv = 10'sd92;
        endcase
        return cv;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/mutating_step_sequencer.sv */
// Mutating eight-step pitch sequencer.
// Requests enter on the s_ stream: s_tuser is the command (0 tick, 1 knob
// write); s_tdata carries the clock level, lock buttons, knob write and the
// random words. Every request gives exactly one result on the m_ stream with
// the playing step, its pitch in hundredths of a volt and the lock mask.
// Settings are written through cfg_we, cfg_index and cfg_wdata; the user
// must write them only while no request is in progress, as the block does
// not enforce it. Index 0 is the length, 1 the mutation period, 2 the octave
// depth and 3 the semitone depth. A knob write passes the knob and result
// states, a tick the tick, finish and result states, with the remainder and
// mutate states before finish when the clock edge starts a mutation, as the
// chosen step is the random word modulo the length, found by a remainder
// unit that takes four bits per cycle. One request is handled at a time; the
// next is accepted in the cycle after its result is registered.
// After reset all steps hold octave one, semitone zero, no locks, step zero.
// If the receiver stalls, the finished result waits in the output register.
// One more request is accepted and processed, and its result waits until
// the earlier one has been taken; further requests wait at the input.
// Depends on msseq_pkg, msseq_ctrl and msseq_dp.
`default_nettype none

module mutating_step_sequencer
    import msseq_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // From bit 0: clock_level, lock_buttons, knob_step, knob_octave_value,
    // knob_semitone_value, random_step, mutation_flags, random_octave,
    // random_semitone, zero padding.
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // command.
    input  wire logic                   s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // From bit 0: current_step, pitch_centivolts, lock_mask, zero padding.
    output logic      [OUT_TDATA_W-1:0] m_tdata
);

    cmd_t    cmd;
    status_t status;

    msseq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    msseq_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

/* rtl/core/msseq_ctrl.sv */
// Controller of the mutating step sequencer: walks each request through its
// phases and holds the result valid flag. Depends on msseq_pkg.
`default_nettype none

module msseq_ctrl
    import msseq_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire logic    s_tuser,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output cmd_t         cmd,
    input  wire status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KNOB,
        ST_TICK,
        ST_MOD,
        ST_MUTATE,
        ST_FINISH,
        ST_RESULT
    } state_t;

    localparam logic [MOD_CNT_W-1:0] MOD_LAST = MOD_CNT_W'(MOD_CYCLES - 1);

    state_t               state_reg, state_next;
    logic [MOD_CNT_W-1:0] mod_cnt_reg, mod_cnt_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        mod_cnt_next  = mod_cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = s_tuser ? ST_KNOB : ST_TICK;
                end
            end
            ST_KNOB: begin
                state_next = ST_RESULT;
            end
            ST_TICK: begin
                mod_cnt_next = '0;
                state_next   = status.mutate_due ? ST_MOD : ST_FINISH;
            end
            ST_MOD: begin
                mod_cnt_next = mod_cnt_reg + 1'b1;
                if (mod_cnt_reg == MOD_LAST) begin
                    state_next = ST_MUTATE;
                end
            end
            ST_MUTATE: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mod_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mod_cnt_reg  <= mod_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        cmd          = '0;
        cmd.latch    = (state_reg == ST_IDLE) && s_tvalid;
        cmd.knob_wr  = (state_reg == ST_KNOB);
        cmd.tick     = (state_reg == ST_TICK);
        cmd.mod_step = (state_reg == ST_MOD);
        cmd.mutate   = (state_reg == ST_MUTATE);
        cmd.finish   = (state_reg == ST_FINISH);
        cmd.out_load = (state_reg == ST_RESULT) && out_free;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && s_tvalid) |=>
            (state_reg == ST_KNOB || state_reg == ST_TICK))
        else $error("accepted request did not start a phase");

    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (m_tvalid_reg && state_reg == ST_IDLE))
        else $error("result load did not raise m_tvalid");

    a_mutate_after_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUTATE) |->
            ($past(state_reg) == ST_MOD && $past(mod_cnt_reg) == MOD_LAST))
        else $error("mutation entered before the remainder was complete");

endmodule

`default_nettype wire

/* rtl/core/msseq_dp.sv */
// Datapath of the mutating step sequencer: settings, step, knob and lock
// state, the step remainder unit, the mutation and the pitch result register.
// Depends on msseq_pkg; driven by msseq_ctrl.
`default_nettype none

module msseq_dp
    import msseq_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    output logic      [OUT_TDATA_W-1:0] m_tdata,
    input  wire cmd_t                   cmd,
    output status_t                     status
);

    logic [LEN_W-1:0]  seq_len_reg;
    logic [PER_W-1:0]  period_reg;
    logic [ODEP_W-1:0] oct_depth_reg;
    logic [SDEP_W-1:0] semi_depth_reg;

    in_item_t          item_reg;

    logic [OCT_W-1:0]  step_oct_reg  [STEP_COUNT];
    logic [SEMI_W-1:0] step_semi_reg [STEP_COUNT];
    logic [OCT_W-1:0]  knob_oct_reg  [STEP_COUNT];
    logic [SEMI_W-1:0] knob_semi_reg [STEP_COUNT];
    logic [OCT_W-1:0]  seen_oct_reg  [STEP_COUNT];
    logic [SEMI_W-1:0] seen_semi_reg [STEP_COUNT];

    logic [STEP_COUNT-1:0] lock_reg;
    logic [STEP_COUNT-1:0] btn_prev_reg;
    logic                  clk_prev_reg;
    logic [IDX_W-1:0]      step_idx_reg;
    logic [PER_W-1:0]      edge_cnt_reg;
    logic                  loaded_reg;

    logic [RAND_W-1:0] mod_word_reg, mod_word_next;
    logic [REM_W-1:0]  rem_reg, rem_next;

    out_item_t         out_reg;

    logic [ALEN_W-1:0]     act_len;
    logic                  clk_rise;
    logic [PER_W-1:0]      edge_inc;
    logic [ALEN_W-1:0]     idx_inc;
    logic [IDX_W-1:0]      choice;
    logic [IDX_W-1:0]      rd_idx;
    logic [OCT_W-1:0]      rd_step_oct, rd_knob_oct, rd_seen_oct;
    logic [SEMI_W-1:0]     rd_step_semi, rd_knob_semi, rd_seen_semi;
    logic [OCT_W-1:0]      dist_oct, mut_oct;
    logic [SEMI_W-1:0]     dist_semi, mut_semi;
    logic [STEP_COUNT-1:0] buttons;

    function automatic logic [SEMI_W-1:0] nudge(input logic [SEMI_W-1:0] v,
                                                 input logic [SEMI_W-1:0] d,
                                                 input logic             up,
                                                 input logic [SEMI_W-1:0] vmax);
        logic [SEMI_W:0]   sum;
        logic [SEMI_W-1:0] res;
        sum = {1'b0, v} + {1'b0, d};
        if (up) begin
            res = (sum > {1'b0, vmax}) ? vmax : sum[SEMI_W-1:0];
        end else begin
            res = (d > v) ? '0 : v - d;
        end
        return res;
    endfunction

    always_comb begin
        if (seq_len_reg == '0) begin
            act_len = ALEN_W'(1);
        end else if (int'(seq_len_reg) > STEP_COUNT) begin
            act_len = ALEN_W'(STEP_COUNT);
        end else begin
            act_len = ALEN_W'(seq_len_reg);
        end
    end

    assign clk_rise          = item_reg.clock_level && !clk_prev_reg;
    assign edge_inc          = edge_cnt_reg + 1'b1;
    assign idx_inc           = ALEN_W'(step_idx_reg) + 1'b1;
    assign status.mutate_due = clk_rise && (edge_inc >= period_reg);
    assign buttons           = STEP_COUNT'(item_reg.lock_buttons);

    // Restoring remainder of the random word by the active length.
    always_comb begin
        logic [RAND_W-1:0] w;
        logic [REM_W-1:0]  r;
        w = mod_word_reg;
        r = rem_reg;
        for (int j = 0; j < MOD_BITS; j++) begin
            r = {r[REM_W-2:0], w[RAND_W-1]};
            w = {w[RAND_W-2:0], 1'b0};
            if (r >= REM_W'(act_len)) begin
                r = r - REM_W'(act_len);
            end
        end
        mod_word_next = w;
        rem_next      = r;
    end

    assign choice = IDX_W'(rem_reg);
    assign rd_idx = cmd.mutate ? choice : step_idx_reg;

    assign rd_step_oct  = step_oct_reg[rd_idx];
    assign rd_step_semi = step_semi_reg[rd_idx];
    assign rd_knob_oct  = knob_oct_reg[rd_idx];
    assign rd_knob_semi = knob_semi_reg[rd_idx];
    assign rd_seen_oct  = seen_oct_reg[rd_idx];
    assign rd_seen_semi = seen_semi_reg[rd_idx];

    assign dist_oct  = item_reg.random_octave & ODEP_W'(oct_depth_reg + 1'b1);
    assign dist_semi = item_reg.random_semitone & SDEP_W'(semi_depth_reg + 1'b1);
    assign mut_oct   = OCT_W'(nudge(SEMI_W'(rd_step_oct), SEMI_W'(dist_oct),
                                    item_reg.mutation_flags[1], SEMI_W'(OCT_MAX)));
    assign mut_semi  = nudge(rd_step_semi, dist_semi, item_reg.mutation_flags[3], SEMI_MAX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_len_reg    <= LEN_W'(8);
            period_reg     <= PER_W'(16);
            oct_depth_reg  <= ODEP_W'(1);
            semi_depth_reg <= SDEP_W'(11);
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_LENGTH:     seq_len_reg    <= cfg_wdata[LEN_W-1:0];
                CFG_PERIOD:     period_reg     <= cfg_wdata[PER_W-1:0];
                CFG_OCT_DEPTH:  oct_depth_reg  <= cfg_wdata[ODEP_W-1:0];
                CFG_SEMI_DEPTH: semi_depth_reg <= cfg_wdata[SDEP_W-1:0];
                default:        seq_len_reg    <= seq_len_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            item_reg <= in_item_t'(s_tdata);
        end
        if (cmd.tick) begin
            mod_word_reg <= item_reg.random_step;
            rem_reg      <= '0;
        end else if (cmd.mod_step) begin
            mod_word_reg <= mod_word_next;
            rem_reg      <= rem_next;
        end
        if (cmd.out_load) begin
            out_reg.pad              <= '0;
            out_reg.lock_mask        <= LOCK_W'(lock_reg);
            out_reg.pitch_centivolts <= octave_cv(rd_step_oct) + semitone_cv(rd_step_semi);
            out_reg.current_step     <= OSTEP_W'(step_idx_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STEP_COUNT; i++) begin
                step_oct_reg[i]  <= OCT_W'(1);
                step_semi_reg[i] <= '0;
                knob_oct_reg[i]  <= OCT_W'(1);
                knob_semi_reg[i] <= '0;
                seen_oct_reg[i]  <= OCT_W'(1);
                seen_semi_reg[i] <= '0;
            end
            lock_reg     <= '0;
            btn_prev_reg <= '0;
            clk_prev_reg <= 1'b0;
            step_idx_reg <= '0;
            edge_cnt_reg <= '0;
            loaded_reg   <= 1'b0;
        end else begin
            if (cmd.knob_wr && int'(item_reg.knob_step) < STEP_COUNT) begin
                knob_oct_reg[IDX_W'(item_reg.knob_step)] <=
                    (item_reg.knob_octave_value > OCT_MAX) ? OCT_MAX : item_reg.knob_octave_value;
                knob_semi_reg[IDX_W'(item_reg.knob_step)] <=
                    (item_reg.knob_semitone_value > SEMI_MAX) ? SEMI_MAX
                                                              : item_reg.knob_semitone_value;
            end
            if (cmd.tick) begin
                if (!loaded_reg) begin
                    for (int i = 0; i < STEP_COUNT; i++) begin
                        step_oct_reg[i]  <= knob_oct_reg[i];
                        step_semi_reg[i] <= knob_semi_reg[i];
                        seen_oct_reg[i]  <= knob_oct_reg[i];
                        seen_semi_reg[i] <= knob_semi_reg[i];
                    end
                    lock_reg   <= '0;
                    loaded_reg <= 1'b1;
                end
                if (clk_rise) begin
                    step_idx_reg <= (idx_inc >= act_len) ? '0 : IDX_W'(idx_inc);
                    edge_cnt_reg <= (edge_inc >= period_reg) ? '0 : edge_inc;
                end
                clk_prev_reg <= item_reg.clock_level;
            end
            if (cmd.mutate && !lock_reg[choice]) begin
                if (item_reg.mutation_flags[0]) begin
                    step_oct_reg[choice] <= mut_oct;
                end
                if (item_reg.mutation_flags[2]) begin
                    step_semi_reg[choice] <= mut_semi;
                end
            end
            if (cmd.finish) begin
                lock_reg     <= lock_reg ^ (buttons & ~btn_prev_reg);
                btn_prev_reg <= buttons;
                if (rd_knob_oct != rd_seen_oct) begin
                    step_oct_reg[step_idx_reg] <= rd_knob_oct;
                end
                if (rd_knob_semi != rd_seen_semi) begin
                    step_semi_reg[step_idx_reg] <= rd_knob_semi;
                end
                seen_oct_reg[step_idx_reg]  <= rd_knob_oct;
                seen_semi_reg[step_idx_reg] <= rd_knob_semi;
            end
        end
    end

    assign m_tdata = OUT_TDATA_W'(out_reg);

    a_step_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_step_oct <= OCT_MAX && rd_step_semi <= SEMI_MAX))
        else $error("stored step value out of range");

    a_knob_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_knob_oct <= OCT_MAX && rd_knob_semi <= SEMI_MAX))
        else $error("stored knob value out of range");

    a_loaded_after_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.tick |=> loaded_reg)
        else $error("first tick did not load the steps");

endmodule

`default_nettype wire
